FILE: src/fpfa_pkg.sv
// Shared types and codes for the fixed-partition fit allocator.
`default_nettype none
package fpfa_pkg;

  localparam logic [1:0] POLICY_FIRST = 2'd0;
  localparam logic [1:0] POLICY_BEST  = 2'd1;
  localparam logic [1:0] POLICY_WORST = 2'd2;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_REQUEST = 1'b1;

  localparam int unsigned CMD_W   = 1;
  localparam int unsigned ENTRY_W = 4;
  localparam int unsigned REQ_W   = 16;
  localparam int unsigned OUT_W   = 4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic accept;
    logic write_entry;
    logic scan_rd;
    logic finish;
  } ctl_t;

endpackage
`default_nettype wire

FILE: src/fixed_partition_fit_allocator_top.sv
// Top level of the fixed-partition fit allocator.
//
// Usage:
//   Present in_cmd, in_entry_index and in_size_value with start high; the
//   transaction is taken at a rising edge where start is high and busy is low.
//   A load (in_cmd 0) writes one partition size and frees that partition.
//   A request (in_cmd 1) scans the table and grants a free loaded partition
//   of sufficient size according to the fit policy register.
//   cfg_wr_en with cfg_wr_data writes the fit policy (0 first, 1 best,
//   2 worst, 3 first); write it only while busy is low.
//   Each transaction yields one result: out_valid is high for one cycle with
//   out_granted and out_block_index. The receiver cannot stall the result.
// Sequencing:
//   out_valid rises after the ST_LOAD state for a load, and after the ST_SCAN,
//   ST_DRAIN and ST_FINISH states for a request; the scan reads one table entry
//   per cycle through the single registered read port of the size table and
//   one comparator. busy is low again in the cycle out_valid rises, so the
//   next transaction can be accepted in that cycle.
// Reset:
//   rst_n low clears the loaded and in-use marks and sets first fit.
`default_nettype none
module fixed_partition_fit_allocator_top
  import fpfa_pkg::*;
#(
  parameter int unsigned NUM_PARTS = 16,
  parameter int unsigned SIZE_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [CMD_W-1:0]   in_cmd,
  input  wire logic [ENTRY_W-1:0] in_entry_index,
  input  wire logic [REQ_W-1:0]   in_size_value,
  input  wire logic               cfg_wr_en,
  input  wire logic [1:0]         cfg_wr_data,
  output logic                    out_valid,
  output logic                    out_granted,
  output logic [OUT_W-1:0]        out_block_index
);

  ctl_t ctl;
  logic scan_last;

  fpfa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_cmd    (in_cmd),
    .scan_last (scan_last),
    .ctl       (ctl),
    .busy      (busy)
  );

  fpfa_dp #(
    .NUM_PARTS (NUM_PARTS),
    .SIZE_BITS (SIZE_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .in_entry_index  (in_entry_index),
    .in_size_value   (in_size_value),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .scan_last       (scan_last),
    .out_valid       (out_valid),
    .out_granted     (out_granted),
    .out_block_index (out_block_index)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without preceding work");

  a_ungranted_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_granted |-> out_block_index == '0)
    else $error("ungranted result carries nonzero index");

  a_grant_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_granted |-> 32'(out_block_index) < NUM_PARTS)
    else $error("granted index beyond table");

endmodule
`default_nettype wire

FILE: src/fpfa_ctrl.sv
// Controller state machine sequencing loads and partition scans.
`default_nettype none
module fpfa_ctrl
  import fpfa_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [CMD_W-1:0] in_cmd,
  input  wire logic             scan_last,
  output ctl_t                  ctl,
  output logic                  busy
);

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = (in_cmd == CMD_LOAD) ? ST_LOAD : ST_SCAN;
        end
      end
      ST_LOAD: begin
        state_nxt = ST_IDLE;
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ctl  = '0;
    busy = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy       = 1'b0;
        ctl.accept = start;
      end
      ST_LOAD: begin
        ctl.write_entry = 1'b1;
      end
      ST_SCAN: begin
        ctl.scan_rd = 1'b1;
      end
      ST_DRAIN: begin
        ctl = '0;
      end
      ST_FINISH: begin
        ctl.finish = 1'b1;
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: src/fpfa_dp.sv
// Datapath: partition table, scan comparator, policy register and result register.
`default_nettype none
module fpfa_dp
  import fpfa_pkg::*;
#(
  parameter int unsigned NUM_PARTS = 16,
  parameter int unsigned SIZE_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire ctl_t               ctl,
  input  wire logic [ENTRY_W-1:0] in_entry_index,
  input  wire logic [REQ_W-1:0]   in_size_value,
  input  wire logic               cfg_wr_en,
  input  wire logic [1:0]         cfg_wr_data,
  output logic                    scan_last,
  output logic                    out_valid,
  output logic                    out_granted,
  output logic [OUT_W-1:0]        out_block_index
);

  localparam int unsigned IDX_W = (NUM_PARTS > 1) ? $clog2(NUM_PARTS) : 1;
  localparam int unsigned CMP_W = (SIZE_BITS > REQ_W) ? SIZE_BITS : REQ_W;

  logic [SIZE_BITS-1:0] size_mem [NUM_PARTS];

  logic [1:0]           fit_policy_r;
  logic [ENTRY_W-1:0]   entry_r;
  logic [REQ_W-1:0]     req_r;
  logic [NUM_PARTS-1:0] loaded_r,   loaded_nxt;
  logic [NUM_PARTS-1:0] in_use_r,   in_use_nxt;
  logic [IDX_W-1:0]     addr_r,     addr_nxt;
  logic                 cmp_valid_r;
  logic [IDX_W-1:0]     rd_idx_r;
  logic [SIZE_BITS-1:0] rd_size_r;
  logic                 found_r,    found_nxt;
  logic [IDX_W-1:0]     pick_r,     pick_nxt;
  logic [SIZE_BITS-1:0] pick_size_r, pick_size_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_granted_r, out_granted_nxt;
  logic [OUT_W-1:0]     out_index_r, out_index_nxt;

  logic entry_in_range;
  logic cand;

  assign entry_in_range = 32'(entry_r) < NUM_PARTS;
  assign scan_last      = addr_r == IDX_W'(NUM_PARTS - 1);
  assign cand           = cmp_valid_r && loaded_r[rd_idx_r] && !in_use_r[rd_idx_r]
                          && (CMP_W'(rd_size_r) >= CMP_W'(req_r));

  always_comb begin
    loaded_nxt      = loaded_r;
    in_use_nxt      = in_use_r;
    addr_nxt        = addr_r;
    found_nxt       = found_r;
    pick_nxt        = pick_r;
    pick_size_nxt   = pick_size_r;
    out_valid_nxt   = 1'b0;
    out_granted_nxt = 1'b0;
    out_index_nxt   = '0;

    if (ctl.accept) begin
      addr_nxt  = '0;
      found_nxt = 1'b0;
    end
    if (ctl.scan_rd) begin
      addr_nxt = addr_r + 1'b1;
    end

    if (cand) begin
      priority if (!found_r) begin
        found_nxt     = 1'b1;
        pick_nxt      = rd_idx_r;
        pick_size_nxt = rd_size_r;
      end else if (fit_policy_r == POLICY_BEST && rd_size_r < pick_size_r) begin
        pick_nxt      = rd_idx_r;
        pick_size_nxt = rd_size_r;
      end else if (fit_policy_r == POLICY_WORST && rd_size_r > pick_size_r) begin
        pick_nxt      = rd_idx_r;
        pick_size_nxt = rd_size_r;
      end else begin
        pick_nxt = pick_r;
      end
    end

    if (ctl.write_entry) begin
      out_valid_nxt = 1'b1;
      if (entry_in_range) begin
        loaded_nxt[IDX_W'(entry_r)] = 1'b1;
        in_use_nxt[IDX_W'(entry_r)] = 1'b0;
      end
    end

    if (ctl.finish) begin
      out_valid_nxt = 1'b1;
      if (found_r) begin
        in_use_nxt[pick_r] = 1'b1;
        out_granted_nxt    = 1'b1;
        out_index_nxt      = OUT_W'(pick_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.write_entry && entry_in_range) begin
      size_mem[IDX_W'(entry_r)] <= SIZE_BITS'(req_r);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.scan_rd) begin
      rd_size_r <= size_mem[addr_r];
      rd_idx_r  <= addr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      entry_r <= in_entry_index;
      req_r   <= in_size_value;
    end
    addr_r        <= addr_nxt;
    pick_r        <= pick_nxt;
    pick_size_r   <= pick_size_nxt;
    out_granted_r <= out_granted_nxt;
    out_index_r   <= out_index_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_policy_r <= POLICY_FIRST;
      loaded_r     <= '0;
      in_use_r     <= '0;
      cmp_valid_r  <= 1'b0;
      found_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        fit_policy_r <= cfg_wr_data;
      end
      loaded_r    <= loaded_nxt;
      in_use_r    <= in_use_nxt;
      cmp_valid_r <= ctl.scan_rd;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_granted     = out_granted_r;
  assign out_block_index = out_index_r;

endmodule
`default_nettype wire
